// ===== design/tsn_pkg.sv =====
// Shared types and constants for the texture sampler (nearest and row-linear).
// No dependencies; every other file of the block but tsn_ram imports this package.
`default_nettype none

package tsn_pkg;

	// Field widths
	localparam int DIM_W    = 13;   // texture width / height register
	localparam int CC_W     = 3;    // bytes per texel register
	localparam int COORD_W  = 17;   // Q1.16 coordinate
	localparam int FRAC_W   = 16;   // column fraction
	localparam int COL_W    = 14;   // column may pass the last one when u > 1.0
	localparam int ROW_W    = 13;
	localparam int LADDR_W  = 16;
	localparam int BYTE_W   = 8;
	localparam int CPOS_W   = 30;   // u * span, v' * span
	localparam int POS_W    = 27;   // row * width + column, or a load address
	localparam int PROD_W   = 30;   // texel index times stride

	localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;

	// Command codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Register map, indexed by paddr[3:2]
	localparam int           REG_IDX_W      = 2;
	localparam logic [1:0]   REG_TEX_WIDTH  = 2'd0;
	localparam logic [1:0]   REG_TEX_HEIGHT = 2'd1;
	localparam logic [1:0]   REG_CHANNELS   = 2'd2;

	// Command queue between front and back
	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [DIM_W-1:0] tex_width;
		logic [DIM_W-1:0] tex_height;
		logic [CC_W-1:0]  channel_count;
	} cfg_t;

	typedef struct packed {
		logic              op;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] ldata;
		logic [FRAC_W-1:0] frac;
		logic              use_next;
	} qent_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

`default_nettype wire

// ===== design/tsn_if.sv =====
// Valid/ready channel interfaces for sample/load words and result words.
// Depends on tsn_pkg for the field widths.
`default_nettype none

interface tsn_in_if import tsn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [LADDR_W-1:0] load_addr;
	logic [BYTE_W-1:0]  load_byte;
	logic [COORD_W-1:0] coord_u;
	logic [COORD_W-1:0] coord_v;
	logic               filter_linear;

	modport source (output valid, op, load_addr, load_byte, coord_u, coord_v, filter_linear,
		input ready);
	modport sink (input valid, op, load_addr, load_byte, coord_u, coord_v, filter_linear,
		output ready);
endinterface

interface tsn_out_if import tsn_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] red;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== design/tsn_ram.sv =====
// Generic single-port RAM, one write or one read per cycle, registered read data.
// No dependencies.
`default_nettype none

module tsn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// ===== design/tsn_front.sv =====
// Front end: accepts words, works out column, fraction and texel index.
// Two-stage pipeline feeding the command queue; depends on tsn_pkg, tsn_if.
`default_nettype none

module tsn_front import tsn_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	tsn_in_if.sink      smp,
	input  wire qstat_t qstat,
	output      logic   push,
	output      qent_t  push_data
);

	logic              adv;
	logic [DIM_W-1:0]  wspan;
	logic [DIM_W-1:0]  hspan;
	logic [COORD_W-1:0] v_clamp;
	logic [COORD_W-1:0] v_inv;
	logic [CPOS_W-1:0] colpos_d;
	logic [CPOS_W-1:0] rowpos_d;

	logic               v_s1;
	logic               op_s1;
	logic               lin_s1;
	logic [LADDR_W-1:0] addr_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic [CPOS_W-1:0]  colpos_s1;
	logic [CPOS_W-1:0]  rowpos_s1;

	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic [POS_W-1:0]  texel_pos;
	qent_t             ent_d;

	logic  v_s2;
	qent_t ent_s2;

	// Whole pipe holds while the last stage waits on a full queue
	assign adv       = !(v_s2 && qstat.full);
	assign smp.ready = adv;
	assign push      = v_s2 && !qstat.full;
	assign push_data = ent_s2;

	// Spans; a zero size behaves like one
	assign wspan = (cfg.tex_width == '0) ? '0 : cfg.tex_width - DIM_W'(1);
	assign hspan = (cfg.tex_height == '0) ? '0 : cfg.tex_height - DIM_W'(1);

	// v saturates at 1.0, rows counted from the top
	assign v_clamp  = (smp.coord_v > COORD_ONE) ? COORD_ONE : smp.coord_v;
	assign v_inv    = COORD_ONE - v_clamp;
	assign colpos_d = CPOS_W'(smp.coord_u) * CPOS_W'(wspan);
	assign rowpos_d = CPOS_W'(v_inv) * CPOS_W'(hspan);

	// Stage 1: position products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1     <= smp.op;
			lin_s1    <= smp.filter_linear;
			addr_s1   <= smp.load_addr;
			byte_s1   <= smp.load_byte;
			colpos_s1 <= colpos_d;
			rowpos_s1 <= rowpos_d;
		end
	end

	// Stage 2: texel index and neighbour decision
	assign col       = colpos_s1[CPOS_W-1:FRAC_W];
	assign row       = rowpos_s1[FRAC_W+ROW_W-1:FRAC_W];
	assign texel_pos = POS_W'(row) * POS_W'(cfg.tex_width) + POS_W'(col);

	always_comb begin
		ent_d.op       = op_s1;
		ent_d.ldata    = byte_s1;
		ent_d.frac     = colpos_s1[FRAC_W-1:0];
		ent_d.use_next = lin_s1 && (col != COL_W'(wspan));
		ent_d.pos      = (op_s1 == OP_SAMPLE) ? texel_pos : POS_W'(addr_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s2 <= ent_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/tsn_queue.sv =====
// Short command queue between front end and back end.
// Register-based ring buffer; depends on tsn_pkg.
`default_nettype none

module tsn_queue import tsn_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire qent_t  push_data,
	input  wire logic   pop,
	output      qent_t  head,
	output      qstat_t qstat
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	qent_t            ent_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head        = ent_q[rd_ptr_q];
	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == CNT_W'(Q_DEPTH));

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/tsn_back.sv =====
// Back end: scales the texel index, wraps it to the memory size, then writes a
// load byte or fetches bytes from the texture RAM one per cycle and blends.
// Depends on tsn_pkg, tsn_if and tsn_ram.
`default_nettype none

module tsn_back import tsn_pkg::*; #(
	parameter int TEX_BYTES = 65536
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire qent_t  head,
	input  wire qstat_t qstat,
	output      logic   pop,
	tsn_out_if.source   res
);

	localparam int  AW        = $clog2(TEX_BYTES);
	localparam bit  POW2      = (TEX_BYTES & (TEX_BYTES - 1)) == 0;
	localparam int  RED_STEPS = 3;
	localparam int  RC_W      = $clog2(RED_STEPS);
	// Quotient estimate never exceeds 2^(PROD_W-AW+1) for a size above 2^(AW-1)
	localparam int  RECIP_W   = PROD_W - AW + 1;
	localparam int  RP_W      = PROD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << PROD_W) / 64'(TEX_BYTES));
	localparam logic [PROD_W-1:0]  TB_P  = PROD_W'(TEX_BYTES);
	localparam logic [AW:0]        TB_A  = (AW + 1)'(TEX_BYTES);

	localparam int         ST_W      = 3;
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCALE  = 3'd1;
	localparam logic [2:0] ST_REDUCE = 3'd2;
	localparam logic [2:0] ST_ACCESS = 3'd3;
	localparam logic [2:0] ST_LAST   = 3'd4;
	localparam logic [2:0] ST_BLEND  = 3'd5;

	logic [ST_W-1:0]    state_q;
	qent_t              ent_q;
	logic [PROD_W-1:0]  rem_q;
	logic [RECIP_W-1:0] quo_q;
	logic [RC_W-1:0]    rcnt_q;
	logic [2:0]         rd_i_q;
	logic               cap_v_q;
	logic [2:0]         cap_i_q;
	logic [BYTE_W-1:0]  bytes_q [6];

	logic              out_v_q;
	logic [BYTE_W-1:0] red_q;
	logic [BYTE_W-1:0] green_q;
	logic [BYTE_W-1:0] blue_q;

	logic              gray;
	logic [2:0]        rd_last;
	logic [3:0]        off;
	logic [AW:0]       addr_sum;
	logic [AW:0]       addr_wrap;
	logic [AW-1:0]     ram_addr;
	logic              ram_we;
	logic              issue;
	logic [BYTE_W-1:0] ram_rdata;
	logic [PROD_W-1:0] scaled;
	logic [RP_W-1:0]   recip_prod;
	logic [PROD_W+1:0] quo_prod;
	logic              blend_fire;
	logic [BYTE_W-1:0] cur0, cur1, cur2, nxt0, nxt1, nxt2;

	// Signed-magnitude blend, truncated toward zero
	function automatic logic [BYTE_W-1:0] lerp8(input logic [BYTE_W-1:0] cur,
		input logic [BYTE_W-1:0] nxt, input logic [FRAC_W-1:0] frac);
		logic [BYTE_W-1:0] d;
		logic [23:0]       p;
		d = (nxt >= cur) ? nxt - cur : cur - nxt;
		p = 24'(frac) * 24'(d);
		return (nxt >= cur) ? cur + p[23:16] : cur - p[23:16];
	endfunction

	assign gray    = (cfg.channel_count == CC_W'(1));
	assign pop     = (state_q == ST_IDLE) && !qstat.empty;
	assign rd_last = gray ? (ent_q.use_next ? 3'd1 : 3'd0) : (ent_q.use_next ? 3'd5 : 3'd2);

	// Byte offset of the current read: three RGB bytes (one in gray), then the neighbour's
	always_comb begin
		if (gray || rd_i_q < 3'd3) begin
			off = 4'(rd_i_q);
		end else begin
			off = 4'(cfg.channel_count) + 4'(rd_i_q) - 4'd3;
		end
	end

	// The low AW bits of rem_q are below the memory size here, so one subtract wraps it
	assign addr_sum  = (AW + 1)'(rem_q[AW-1:0]) + (AW + 1)'(off);
	assign addr_wrap = (addr_sum >= TB_A) ? addr_sum - TB_A : addr_sum;
	assign ram_addr  = addr_wrap[AW-1:0];
	assign ram_we    = (state_q == ST_ACCESS) && (ent_q.op == OP_LOAD);
	assign issue     = (state_q == ST_ACCESS) && (ent_q.op == OP_SAMPLE);

	assign scaled = PROD_W'(ent_q.pos)
		* PROD_W'((ent_q.op == OP_SAMPLE) ? cfg.channel_count : CC_W'(1));

	// Quotient estimate by reciprocal, then quotient times size
	assign recip_prod = RP_W'(rem_q) * RP_W'(RECIP);
	assign quo_prod   = (PROD_W + 2)'(quo_q) * (PROD_W + 2)'(TEX_BYTES);

	tsn_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TEX_BYTES)
	) u_tex_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ent_q.ldata),
		.rdata (ram_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rcnt_q  <= '0;
			rd_i_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					rcnt_q  <= '0;
					rd_i_q  <= '0;
					state_q <= POW2 ? ST_ACCESS : ST_REDUCE;
				end
				ST_REDUCE: begin
					if (rcnt_q == RC_W'(RED_STEPS - 1)) begin
						state_q <= ST_ACCESS;
					end else begin
						rcnt_q <= rcnt_q + RC_W'(1);
					end
				end
				ST_ACCESS: begin
					if (ent_q.op == OP_LOAD) begin
						state_q <= ST_IDLE;
					end else if (rd_i_q == rd_last) begin
						state_q <= ST_LAST;
					end else begin
						rd_i_q <= rd_i_q + 3'd1;
					end
				end
				ST_LAST: begin
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					if (blend_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command latch, scaling and modulo: estimate quotient (low by at most one),
	// subtract quotient times size, then one conditional subtract
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		if (state_q == ST_SCALE) begin
			rem_q <= scaled;
		end else if (state_q == ST_REDUCE) begin
			if (rcnt_q == RC_W'(0)) begin
				quo_q <= recip_prod[RP_W-1:PROD_W];
			end else if (rcnt_q == RC_W'(1)) begin
				rem_q <= rem_q - quo_prod[PROD_W-1:0];
			end else if (rem_q >= TB_P) begin
				rem_q <= rem_q - TB_P;
			end
		end
	end

	// Read data lands in the cycle after the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_v_q <= 1'b0;
		end else begin
			cap_v_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		cap_i_q <= rd_i_q;
		if (cap_v_q) begin
			bytes_q[cap_i_q] <= ram_rdata;
		end
	end

	// Texel pair, gray replicated
	assign cur0 = bytes_q[0];
	assign cur1 = gray ? bytes_q[0] : bytes_q[1];
	assign cur2 = gray ? bytes_q[0] : bytes_q[2];
	assign nxt0 = gray ? bytes_q[1] : bytes_q[3];
	assign nxt1 = gray ? bytes_q[1] : bytes_q[4];
	assign nxt2 = gray ? bytes_q[1] : bytes_q[5];

	assign blend_fire = (state_q == ST_BLEND) && (!out_v_q || res.ready);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (blend_fire) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (blend_fire) begin
			red_q   <= ent_q.use_next ? lerp8(cur0, nxt0, ent_q.frac) : cur0;
			green_q <= ent_q.use_next ? lerp8(cur1, nxt1, ent_q.frac) : cur1;
			blue_q  <= ent_q.use_next ? lerp8(cur2, nxt2, ent_q.frac) : cur2;
		end
	end

	assign res.valid = out_v_q;
	assign res.red   = red_q;
	assign res.green = green_q;
	assign res.blue  = blue_q;

endmodule

`default_nettype wire

// ===== design/texture_sampler_nearest_linear_unit.sv =====
// Top level of the texture sampler: register file, front end, queue, back end.
// Depends on tsn_pkg, tsn_if, tsn_front, tsn_queue, tsn_back, tsn_ram.
//
//  Channel     Dir  Handshake          Word
//  sample_in   in   valid/ready        op, load_addr, load_byte, coord_u, coord_v, filter_linear
//  sample_out  out  valid/ready        red, green, blue
//  apb         in   psel/penable/pready tex_width, tex_height, channel_count
//
// The back end takes one word at a time and sets the rate: a load passes IDLE,
// SCALE and ACCESS; a sample passes IDLE, SCALE, ACCESS once per read (reads:
// 3 RGB or 1 gray, doubled when blending), LAST and BLEND. Sizes that are not a
// power of two add REDUCE (quotient estimate, subtract, conditional subtract)
// for the address modulo. Every read uses the one port of the texture RAM. The
// front pipeline (stage 1, stage 2) keeps taking words into a 2-entry queue while
// a result waits, until the queue fills. Texture memory is not cleared by reset.
`default_nettype none

module texture_sampler_nearest_linear_unit import tsn_pkg::*; #(
	parameter int TEX_BYTES = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	tsn_in_if.sink           sample_in,
	tsn_out_if.source        sample_out
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_we;
	logic                 q_push;
	logic                 q_pop;
	qent_t                q_in;
	qent_t                q_head;
	qstat_t               q_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_we  = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tex_width     <= DIM_W'(1);
			cfg_q.tex_height    <= DIM_W'(1);
			cfg_q.channel_count <= CC_W'(3);
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_TEX_WIDTH:  cfg_q.tex_width     <= pwdata[DIM_W-1:0];
				REG_TEX_HEIGHT: cfg_q.tex_height    <= pwdata[DIM_W-1:0];
				REG_CHANNELS:   cfg_q.channel_count <= pwdata[CC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (reg_idx)
			REG_TEX_WIDTH:  prdata = 32'(cfg_q.tex_width);
			REG_TEX_HEIGHT: prdata = 32'(cfg_q.tex_height);
			REG_CHANNELS:   prdata = 32'(cfg_q.channel_count);
			default:        prdata = '0;
		endcase
	end

	tsn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.smp       (sample_in),
		.qstat     (q_stat),
		.push      (q_push),
		.push_data (q_in)
	);

	tsn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.qstat     (q_stat)
	);

	tsn_back #(
		.TEX_BYTES (TEX_BYTES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (q_head),
		.qstat  (q_stat),
		.pop    (q_pop),
		.res    (sample_out)
	);

	// Queue never overflows or underflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("command popped from an empty queue");

	// A width write lands in the register
	a_width_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && reg_idx == REG_TEX_WIDTH) |=> (cfg_q.tex_width == $past(pwdata[12:0])))
		else $error("texture width register not updated");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for texture_sampler_nearest_linear_unit: texel loads, nearest and
// row-linear samples, checked against a predictor that shadows the texture memory.
// Depends on tsn_pkg, the tsn_in_if / tsn_out_if interfaces and the sampler top level.
`timescale 1ns / 1ps

module tb_top;
	import tsn_pkg::*;

	localparam int TEX_BYTES   = 65536;
	localparam int PHASE_WORDS = 75;
	localparam int N_SHAPES    = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 40;
	localparam longint unsigned LIMIT_NS = 64'd10_000_000;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} texel_t;

	typedef struct packed {
		logic               op;
		logic [LADDR_W-1:0] load_addr;
		logic [BYTE_W-1:0]  load_byte;
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
		logic               lin;
	} tex_cmd_t;

	typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_REG} row_kind_t;

	// addr carries the byte address of a load or the register index;
	// value carries the load byte or the register value
	typedef struct packed {
		row_kind_t          kind;
		logic [LADDR_W-1:0] addr;
		logic [DIM_W-1:0]   value;
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
		logic               lin;
		logic               typed;
		texel_t             want;
	} dir_row_t;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [CC_W-1:0]  cc;
	} tex_shape_t;

	localparam texel_t NO_TEXEL = '0;
	localparam int DIR_ROWS = 24;

	// Directed words; only the reset-shape samples carry a typed answer
	localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
		'{ROW_LOAD,   16'h0000, 13'h000, 17'h00000, 17'h00000, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_LOAD,   16'h0001, 13'h0ff, 17'h00000, 17'h00000, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_LOAD,   16'h0002, 13'h080, 17'h00000, 17'h00000, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h00000, 17'h00000, 1'b0, 1'b1,
			'{8'h00, 8'hff, 8'h80}},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h1ffff, 17'h1ffff, 1'b1, 1'b1,
			'{8'h00, 8'hff, 8'h80}},
		'{ROW_LOAD,   16'hffff, 13'h0ff, 17'h00000, 17'h00000, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_LOAD,   16'hfffe, 13'h05a, 17'h00000, 17'h00000, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_TEX_WIDTH),  13'd4, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_TEX_HEIGHT), 13'd2, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h08000, 17'h00000, 1'b1, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h10000, 17'h10000, 1'b1, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h1ffff, 17'h18000, 1'b1, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h0ffff, 17'h0ffff, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_CHANNELS), 13'd1, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h05555, 17'h08000, 1'b1, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h0c000, 17'h04000, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_TEX_WIDTH), 13'd0, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_CHANNELS),  13'd4, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h1ffff, 17'h00000, 1'b1, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_TEX_WIDTH),  13'd4096, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_TEX_HEIGHT), 13'd4096, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h1ffff, 17'h00000, 1'b1, 1'b0, NO_TEXEL},
		'{ROW_REG, 16'(REG_CHANNELS), 13'd0, 17'h0, 17'h0, 1'b0, 1'b0, NO_TEXEL},
		'{ROW_SAMPLE, 16'h0000, 13'h000, 17'h12345, 17'h03000, 1'b1, 1'b0, NO_TEXEL}
	};

	// Texture shapes of the random phases, extremes included
	localparam tex_shape_t SHAPES [0:N_SHAPES-1] = '{
		'{13'd1,    13'd1,    3'd3},
		'{13'd16,   13'd16,   3'd3},
		'{13'd4096, 13'd4096, 3'd4},
		'{13'd7,    13'd5,    3'd1},
		'{13'd0,    13'd4096, 3'd0},
		'{13'd3,    13'd4096, 3'd2},
		'{13'd4096, 13'd1,    3'd7},
		'{13'd33,   13'd9,    3'd4}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tsn_in_if  sample_in ();
	tsn_out_if sample_out ();

	texture_sampler_nearest_linear_unit #(
		.TEX_BYTES(TEX_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sample_in (sample_in),
		.sample_out(sample_out)
	);

	// Shadow of the texture memory and the registers
	logic [BYTE_W-1:0] tex_mem [0:TEX_BYTES-1];
	bit                tex_written [0:TEX_BYTES-1];
	logic [DIM_W-1:0]  cfg_width  = 13'd1;
	logic [DIM_W-1:0]  cfg_height = 13'd1;
	logic [CC_W-1:0]   cfg_chans  = 3'd3;

	texel_t pending_texels [$];
	int     fail_count = 0;
	int     words_sent = 0;
	bit     quiet      = 1'b0;
	bit     hold_req   = 1'b0;
	bit     hold_done  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAIL texture_sampler_nearest_linear_unit");
		$finish;
	end

	// Texel position of a sample: base byte address, blend flag and column fraction
	function automatic void locate_texel(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
			input logic lin, output longint unsigned base, output bit blend_on,
			output int unsigned frac);
		longint unsigned uu, vv, wspan, hspan, colpos, col, row;
		uu = 64'(u);
		vv = (v > COORD_ONE) ? 64'(COORD_ONE) : 64'(v);
		wspan = (cfg_width == '0) ? 64'd0 : 64'(cfg_width) - 64'd1;
		hspan = (cfg_height == '0) ? 64'd0 : 64'(cfg_height) - 64'd1;
		colpos = uu * wspan;
		col = colpos >> 16;
		frac = 32'(colpos[15:0]);
		row = ((64'd65536 - vv) * hspan) >> 16;
		base = (row * 64'(cfg_width) + col) * 64'(cfg_chans);
		blend_on = lin && (col != wspan);
	endfunction

	function automatic texel_t read_texel(input longint unsigned base);
		texel_t t;
		t.red = tex_mem[base % TEX_BYTES];
		if (cfg_chans == 1) begin
			t.green = t.red;
			t.blue  = t.red;
		end else begin
			t.green = tex_mem[(base + 1) % TEX_BYTES];
			t.blue  = tex_mem[(base + 2) % TEX_BYTES];
		end
		return t;
	endfunction

	// Blend toward the neighbour, step truncated toward zero
	function automatic logic [7:0] lerp_channel(input logic [7:0] cur, input logic [7:0] nxt,
			input int unsigned frac);
		int unsigned step;
		if (nxt >= cur) begin
			step = (frac * (nxt - cur)) >> 16;
			return cur + step[7:0];
		end
		step = (frac * (cur - nxt)) >> 16;
		return cur - step[7:0];
	endfunction

	function automatic texel_t texel_predict(input logic [COORD_W-1:0] u,
			input logic [COORD_W-1:0] v, input logic lin);
		longint unsigned base;
		bit              blend_on;
		int unsigned     frac;
		texel_t          cur, nxt;
		locate_texel(u, v, lin, base, blend_on, frac);
		cur = read_texel(base);
		if (blend_on) begin
			nxt = read_texel(base + 64'(cfg_chans));
			cur.red   = lerp_channel(cur.red, nxt.red, frac);
			cur.green = lerp_channel(cur.green, nxt.green, frac);
			cur.blue  = lerp_channel(cur.blue, nxt.blue, frac);
		end
		return cur;
	endfunction

	// One input word; the shadow is updated at the accepting edge
	task automatic send_cmd(input tex_cmd_t c, input bit typed, input texel_t want);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			sample_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		sample_in.valid         <= 1'b1;
		sample_in.op            <= c.op;
		sample_in.load_addr     <= c.load_addr;
		sample_in.load_byte     <= c.load_byte;
		sample_in.coord_u       <= c.u;
		sample_in.coord_v       <= c.v;
		sample_in.filter_linear <= c.lin;
		do @(posedge clk); while (!sample_in.ready);
		if (c.op == OP_LOAD) begin
			tex_mem[c.load_addr]     = c.load_byte;
			tex_written[c.load_addr] = 1'b1;
		end else begin
			pending_texels.push_back(typed ? want : texel_predict(c.u, c.v, c.lin));
		end
		words_sent++;
	endtask

	task automatic send_load(input logic [LADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
		tex_cmd_t c;
		c.op        = OP_LOAD;
		c.load_addr = addr;
		c.load_byte = data;
		c.u         = COORD_W'($urandom_range(0, 131071));
		c.v         = COORD_W'($urandom_range(0, 131071));
		c.lin       = 1'($urandom_range(0, 1));
		send_cmd(c, 1'b0, NO_TEXEL);
	endtask

	// Fills every byte the sample will read that was never loaded, then samples
	task automatic send_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
			input logic lin, input bit typed, input texel_t want);
		longint unsigned base, spot;
		bit              blend_on;
		int unsigned     frac;
		int              n_bytes;
		tex_cmd_t        c;
		locate_texel(u, v, lin, base, blend_on, frac);
		n_bytes = (cfg_chans == 1) ? 1 : 3;
		for (int t = 0; t < (blend_on ? 2 : 1); t++) begin
			for (int k = 0; k < n_bytes; k++) begin
				spot = (base + t * cfg_chans + k) % TEX_BYTES;
				if (!tex_written[spot])
					send_load(spot[LADDR_W-1:0], BYTE_W'($urandom_range(0, 255)));
			end
		end
		c.op        = OP_SAMPLE;
		c.load_addr = LADDR_W'($urandom_range(0, 65535));
		c.load_byte = BYTE_W'($urandom_range(0, 255));
		c.u         = u;
		c.v         = v;
		c.lin       = lin;
		send_cmd(c, typed, want);
	endtask

	// Stop offering, let every result out, then leave room for trailing loads
	task automatic await_results();
		sample_in.valid <= 1'b0;
		while (pending_texels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_TEX_WIDTH:  cfg_width  = value[DIM_W-1:0];
			REG_TEX_HEIGHT: cfg_height = value[DIM_W-1:0];
			REG_CHANNELS:   cfg_chans  = value[CC_W-1:0];
			default: ;
		endcase
	endtask

	// Coordinates lean on the edges of the range and past 1.0
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return COORD_ONE;
			2:       return '1;
			3:       return COORD_W'($urandom_range(65537, 131071));
			default: return COORD_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// Stimulus: reset, directed table, then random phases over several shapes
	initial begin
		dir_row_t row;
		int       start;
		bit       paused;
		arst_n                  <= 1'b0;
		psel                    <= 1'b0;
		penable                 <= 1'b0;
		pwrite                  <= 1'b0;
		paddr                   <= '0;
		pwdata                  <= '0;
		sample_in.valid         <= 1'b0;
		sample_in.op            <= OP_LOAD;
		sample_in.load_addr     <= '0;
		sample_in.load_byte     <= '0;
		sample_in.coord_u       <= '0;
		sample_in.coord_v       <= '0;
		sample_in.filter_linear <= 1'b0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			case (row.kind)
				ROW_LOAD:   send_load(row.addr, row.value[BYTE_W-1:0]);
				ROW_SAMPLE: send_sample(row.u, row.v, row.lin, row.typed, row.want);
				default: begin
					await_results();
					reg_write(row.addr[REG_IDX_W-1:0], 32'(row.value));
				end
			endcase
		end

		for (int p = 0; p < N_SHAPES; p++) begin
			await_results();
			reg_write(REG_TEX_WIDTH, 32'(SHAPES[p].w));
			reg_write(REG_TEX_HEIGHT, 32'(SHAPES[p].h));
			reg_write(REG_CHANNELS, 32'(SHAPES[p].cc));
			quiet = (p == N_SHAPES - 1);
			start = words_sent;
			while (words_sent - start < PHASE_WORDS) begin
				// long receiver hold-off while words keep coming
				if (p == 1 && !hold_req && words_sent - start >= 20)
					hold_req = 1'b1;
				// sender pause until the block has drained
				if (p == 3 && !paused && words_sent - start >= 30) begin
					await_results();
					paused = 1'b1;
				end
				if ($urandom_range(0, 3) == 0)
					send_load(LADDR_W'($urandom_range(0, 65535)),
						BYTE_W'($urandom_range(0, 255)));
				else
					send_sample(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)), 1'b0,
						NO_TEXEL);
			end
		end

		sample_in.valid <= 1'b0;
		while (pending_texels.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS texture_sampler_nearest_linear_unit");
		end else begin
			$display("FAIL texture_sampler_nearest_linear_unit");
		end
		$finish;
	end

	// Result side back-pressure: short random bursts, one long hold-off on request
	initial begin
		sample_out.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				sample_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				sample_out.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				sample_out.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Each result word against the oldest predicted texel
	always @(posedge clk) begin : check_texels
		texel_t want;
		if (arst_n && sample_out.valid && sample_out.ready) begin
			if (pending_texels.size() == 0) begin
				$error("unexpected result word r=%0d g=%0d b=%0d",
					sample_out.red, sample_out.green, sample_out.blue);
				fail_count++;
			end else begin
				want = pending_texels.pop_front();
				if (sample_out.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, sample_out.red);
					fail_count++;
				end
				if (sample_out.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, sample_out.green);
					fail_count++;
				end
				if (sample_out.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, sample_out.blue);
					fail_count++;
				end
			end
		end
	end

endmodule
